### hw/rtl/pdlb_pkg.sv
// Shared types and constants for the press-duration LED blink controller.
// Depends on nothing; every RTL file of the block imports it.
`timescale 1ns / 1ps

package pdlb_pkg;

  localparam int NUM_CH        = 4;
  localparam int TICK_W        = 12;
  localparam int MS_W          = 16;
  localparam int CFG_W         = 16;
  localparam int CFG_IDX_W     = 1;

  // Tick periods of the refresh latch and the two blink rates.
  localparam int REFRESH_TICKS = 1000;
  localparam int FAST_TICKS    = 2000;
  localparam int SLOW_TICKS    = 4000;

  localparam logic [MS_W-1:0] TAP_LIMIT_RESET  = MS_W'(1500);
  localparam logic [MS_W-1:0] HOLD_LIMIT_RESET = MS_W'(3000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TAP_LIMIT  = 1'b0,
    CFG_HOLD_LIMIT = 1'b1
  } cfg_index_t;

  typedef enum logic [0:0] {
    REQ_TICK  = 1'b0,
    REQ_PRESS = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    MODE_ON    = 2'd0,
    MODE_OFF   = 2'd1,
    MODE_SHORT = 2'd2,
    MODE_LONG  = 2'd3
  } mode_t;

  typedef struct packed {
    logic [NUM_CH-1:0] led_levels;
    mode_t             mode_back;
    mode_t             mode_front;
    mode_t             mode_left;
    mode_t             mode_right;
  } result_t;

endpackage

### hw/rtl/press_duration_led_blink_controller_unit.sv
// Press-duration LED blink controller, top level.
// Depends on pdlb_pkg for mode codes, tick periods and the result word type.
`timescale 1ns / 1ps

// The block takes one input word per clock when unstalled: either a timer tick
// or a finished button press (channel number and duration in ms). Each accepted
// word yields exactly one result word, the LED levels and the four channel
// modes after the update. All state updates happen in a single combinational
// pass between the channel state registers and the result register, so a word
// can be accepted every cycle unless in_stall holds it. The result side has a
// two-word buffer (output register plus skid register): input stall rises only
// when both hold words that the downstream side has not yet taken. Configuration
// (tap and hold limits in ms) is written through cfg_write/cfg_index/cfg_data;
// the user must do so only with no word in flight; not enforced by the block.
module press_duration_led_blink_controller_unit
  import pdlb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // configuration write port
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 req_type,
  input  logic [1:0]           button_index,
  input  logic [MS_W-1:0]      press_ms,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [NUM_CH-1:0]    led_levels,
  output logic [1:0]           mode_right,
  output logic [1:0]           mode_left,
  output logic [1:0]           mode_front,
  output logic [1:0]           mode_back
);

  localparam int REFRESH_MULTS = ((1 << TICK_W) - 1) / REFRESH_TICKS;
  localparam int FAST_MULTS    = ((1 << TICK_W) - 1) / FAST_TICKS;
  localparam int SLOW_MULTS    = ((1 << TICK_W) - 1) / SLOW_TICKS;

  // configuration
  logic [MS_W-1:0] tap_limit;
  logic [MS_W-1:0] hold_limit;

  // channel state
  logic [TICK_W-1:0] tick_count, tick_count_next;
  mode_t             channel_mode      [NUM_CH];
  mode_t             channel_mode_next [NUM_CH];
  logic [NUM_CH-1:0] slow_armed, slow_armed_next;
  logic [NUM_CH-1:0] fast_armed, fast_armed_next;
  logic [NUM_CH-1:0] led_drive, led_drive_next;
  logic [NUM_CH-1:0] tap_seen, tap_seen_next;
  logic [NUM_CH-1:0] second_tap, second_tap_next;

  // result buffer
  result_t out_word, skid_word, result_next;
  logic    skid_valid;

  logic in_fire, out_fire;
  logic [TICK_W-1:0] tick_inc;
  logic refresh_hit, fast_hit, slow_hit;

  assign in_stall = skid_valid;
  assign in_fire  = in_valid && !skid_valid;
  assign out_fire = out_valid && !out_stall;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_limit  <= TAP_LIMIT_RESET;
      hold_limit <= HOLD_LIMIT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_TAP_LIMIT:  tap_limit  <= cfg_data;
        CFG_HOLD_LIMIT: hold_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // Period hits: compare the advanced count against every multiple of each
  // period that fits in the counter width.
  assign tick_inc = tick_count + TICK_W'(1);

  always_comb begin
    refresh_hit = 1'b0;
    fast_hit    = 1'b0;
    slow_hit    = 1'b0;
    for (int k = 0; k <= REFRESH_MULTS; k++) begin
      if (tick_inc == TICK_W'(k * REFRESH_TICKS)) refresh_hit = 1'b1;
    end
    for (int k = 0; k <= FAST_MULTS; k++) begin
      if (tick_inc == TICK_W'(k * FAST_TICKS)) fast_hit = 1'b1;
    end
    for (int k = 0; k <= SLOW_MULTS; k++) begin
      if (tick_inc == TICK_W'(k * SLOW_TICKS)) slow_hit = 1'b1;
    end
  end

  // Next channel state for the accepted word.
  always_comb begin
    tick_count_next = tick_count;
    slow_armed_next = slow_armed;
    fast_armed_next = fast_armed;
    led_drive_next  = led_drive;
    tap_seen_next   = tap_seen;
    second_tap_next = second_tap;
    for (int i = 0; i < NUM_CH; i++) channel_mode_next[i] = channel_mode[i];

    if (in_fire) begin
      if (req_t'(req_type) == REQ_TICK) begin
        tick_count_next = tick_inc;
        // Latch modes first, then fast toggle, then slow toggle.
        if (refresh_hit) begin
          for (int i = 0; i < NUM_CH; i++) begin
            if (channel_mode[i] == MODE_ON)  led_drive_next[i] = 1'b1;
            if (channel_mode[i] == MODE_OFF) led_drive_next[i] = 1'b0;
            slow_armed_next[i] = (channel_mode[i] == MODE_SHORT);
            fast_armed_next[i] = (channel_mode[i] == MODE_LONG);
          end
        end
        if (fast_hit) led_drive_next = led_drive_next ^ fast_armed_next;
        if (slow_hit) begin
          led_drive_next  = led_drive_next ^ slow_armed_next;
          tick_count_next = '0;
        end
      end else if (press_ms != '0) begin
        if (press_ms < tap_limit) begin
          // Tap cycle: on, ignored second tap, then off.
          if (!tap_seen[button_index]) begin
            tap_seen_next[button_index]     = 1'b1;
            channel_mode_next[button_index] = MODE_ON;
          end else if (!second_tap[button_index]) begin
            second_tap_next[button_index] = 1'b1;
          end else begin
            second_tap_next[button_index]   = 1'b0;
            tap_seen_next[button_index]     = 1'b0;
            channel_mode_next[button_index] = MODE_OFF;
          end
        end else if (press_ms < hold_limit) begin
          channel_mode_next[button_index] = MODE_SHORT;
        end else begin
          channel_mode_next[button_index] = MODE_LONG;
        end
      end
    end

    result_next.led_levels = led_drive_next;
    result_next.mode_right = channel_mode_next[0];
    result_next.mode_left  = channel_mode_next[1];
    result_next.mode_front = channel_mode_next[2];
    result_next.mode_back  = channel_mode_next[3];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      slow_armed <= '0;
      fast_armed <= '0;
      led_drive  <= '0;
      tap_seen   <= '0;
      second_tap <= '0;
      for (int i = 0; i < NUM_CH; i++) channel_mode[i] <= MODE_OFF;
    end else begin
      tick_count <= tick_count_next;
      slow_armed <= slow_armed_next;
      fast_armed <= fast_armed_next;
      led_drive  <= led_drive_next;
      tap_seen   <= tap_seen_next;
      second_tap <= second_tap_next;
      for (int i = 0; i < NUM_CH; i++) channel_mode[i] <= channel_mode_next[i];
    end
  end

  // Output register with skid: drain the skid word first, else load the new
  // word into the output register when it is free, else park it in the skid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        skid_valid <= 1'b0;
      end
    end else if (in_fire) begin
      if (!out_valid || out_fire) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_fire) out_word <= skid_word;
    end else if (in_fire) begin
      if (!out_valid || out_fire) begin
        out_word <= result_next;
      end else begin
        skid_word <= result_next;
      end
    end
  end

  assign led_levels = out_word.led_levels;
  assign mode_right = out_word.mode_right;
  assign mode_left  = out_word.mode_left;
  assign mode_front = out_word.mode_front;
  assign mode_back  = out_word.mode_back;

endmodule

### sim/tb.sv
// Self-checking testbench for press_duration_led_blink_controller_unit.
// Depends on pdlb_pkg and the block's RTL; predicts every result word from its
// own model of the controller and checks it against the block's result channel.
`timescale 1ns / 1ps

module tb;
  import pdlb_pkg::*;

  // One input word as the driver offers it.
  typedef struct packed {
    req_t            kind;
    logic [1:0]      button;
    logic [MS_W-1:0] ms;
  } in_word_t;

  // Block ports, all inputs at known values from time zero.
  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 cfg_write    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index    = CFG_TAP_LIMIT;
  logic [CFG_W-1:0]     cfg_data     = '0;
  logic                 in_valid     = 1'b0;
  logic                 in_stall;
  logic                 req_type     = REQ_TICK;
  logic [1:0]           button_index = '0;
  logic [MS_W-1:0]      press_ms     = '0;
  logic                 out_valid;
  logic                 out_stall    = 1'b0;
  logic [NUM_CH-1:0]    led_levels;
  logic [1:0]           mode_right;
  logic [1:0]           mode_left;
  logic [1:0]           mode_front;
  logic [1:0]           mode_back;

  press_duration_led_blink_controller_unit dut (.*);

  // Words waiting for the driver, and result words the block still owes.
  in_word_t words_to_send[$];
  result_t  results_due[$];

  // Idling knobs, set per phase; hold-off runs the long receiver stall.
  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  logic hold_off_start   = 1'b0;
  int hold_off_left      = 0;
  int mismatches         = 0;

  // Controller model: limits plus the per-channel state.
  logic [MS_W-1:0]   tap_limit;
  logic [MS_W-1:0]   hold_limit;
  logic [TICK_W-1:0] tick_phase;
  mode_t             ch_mode[NUM_CH];
  logic [NUM_CH-1:0] slow_arm;
  logic [NUM_CH-1:0] fast_arm;
  logic [NUM_CH-1:0] led_drive;
  logic [NUM_CH-1:0] first_tap;
  logic [NUM_CH-1:0] second_tap;

  initial begin
    forever #2 clk = ~clk;
  end

  // Apply one accepted word to the model and return the result word it yields.
  function automatic result_t apply_word(in_word_t w);
    result_t r;
    int i;
    if (w.kind == REQ_TICK) begin
      tick_phase = tick_phase + 1'b1;
      // Refresh first: latch on/off into the LEDs and arm the hold modes.
      if (tick_phase % REFRESH_TICKS == 0) begin
        for (i = 0; i < NUM_CH; i++) begin
          if (ch_mode[i] == MODE_ON || ch_mode[i] == MODE_OFF)
            led_drive[i] = (ch_mode[i] == MODE_ON);
          slow_arm[i] = (ch_mode[i] == MODE_SHORT);
          fast_arm[i] = (ch_mode[i] == MODE_LONG);
        end
      end
      // Then the fast toggle, then the slow toggle, which also wraps the count.
      if (tick_phase % FAST_TICKS == 0)
        led_drive = led_drive ^ fast_arm;
      if (tick_phase % SLOW_TICKS == 0) begin
        led_drive  = led_drive ^ slow_arm;
        tick_phase = '0;
      end
    end else if (w.ms != '0) begin
      if (w.ms < tap_limit) begin
        // Tap cycle: on, ignored, off. Flags survive holds.
        if (!first_tap[w.button]) begin
          first_tap[w.button] = 1'b1;
          ch_mode[w.button]   = MODE_ON;
        end else if (!second_tap[w.button]) begin
          second_tap[w.button] = 1'b1;
        end else begin
          first_tap[w.button]  = 1'b0;
          second_tap[w.button] = 1'b0;
          ch_mode[w.button]    = MODE_OFF;
        end
      end else if (w.ms < hold_limit) begin
        ch_mode[w.button] = MODE_SHORT;
      end else begin
        ch_mode[w.button] = MODE_LONG;
      end
    end
    r.led_levels = led_drive;
    r.mode_right = ch_mode[0];
    r.mode_left  = ch_mode[1];
    r.mode_front = ch_mode[2];
    r.mode_back  = ch_mode[3];
    return r;
  endfunction

  function automatic in_word_t press(logic [1:0] ch, logic [MS_W-1:0] ms);
    return in_word_t'{REQ_PRESS, ch, ms};
  endfunction

  // Ticks carry junk in the button and duration fields; the block must ignore it.
  function automatic in_word_t tick_word(logic [1:0] ch, logic [MS_W-1:0] ms);
    return in_word_t'{REQ_TICK, ch, ms};
  endfunction

  function automatic string show_word(result_t r);
    return $sformatf("led=%b modes r/l/f/b=%0d/%0d/%0d/%0d", r.led_levels,
                     r.mode_right, r.mode_left, r.mode_front, r.mode_back);
  endfunction

  // Driver: predict on acceptance, then offer the next queued word or go idle.
  // Hold the payload while stalled.
  always @(posedge clk) begin
    in_word_t w;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        results_due.push_back(apply_word(in_word_t'{req_t'(req_type), button_index,
                                                    press_ms}));
      if (!in_valid || !in_stall) begin
        if (words_to_send.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          w = words_to_send.pop_front();
          in_valid     <= 1'b1;
          req_type     <= w.kind;
          button_index <= w.button;
          press_ms     <= w.ms;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here so the driver keeps pushing words.
  always @(posedge clk) begin
    if (hold_off_start)
      hold_off_left <= 400;
    else if (hold_off_left != 0)
      hold_off_left <= hold_off_left - 1;
  end

  // Monitor: check each accepted result word against the oldest prediction.
  always @(posedge clk) begin
    result_t want;
    result_t got;
    got.led_levels = led_levels;
    got.mode_right = mode_t'(mode_right);
    got.mode_left  = mode_t'(mode_left);
    got.mode_front = mode_t'(mode_front);
    got.mode_back  = mode_t'(mode_back);
    if (!rst && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: result word with none expected: %s", $time, show_word(got));
        mismatches++;
      end else begin
        want = results_due.pop_front();
        if (want !== got) begin
          if (mismatches < 10)
            $display("%0t: mismatch: expected %s, got %s", $time, show_word(want),
                     show_word(got));
          mismatches++;
        end
      end
    end
    out_stall <= (hold_off_left != 0) || ($urandom_range(99) < receiver_stall_pct);
  end

  // Wait until every word is sent and every result is back, then let the
  // pipeline settle.
  task automatic drain();
    while (words_to_send.size() != 0 || in_valid || results_due.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Queue about the given number of random words: presses aimed at the current
  // limits and their edges, mixed with tick bursts.
  task automatic queue_random(int words);
    int d;
    int n;
    int top;
    int added;
    top   = (tap_limit > hold_limit) ? int'(tap_limit) : int'(hold_limit);
    added = 0;
    while (added < words) begin
      if ($urandom_range(9) < 6) begin
        case ($urandom_range(9))
          0:       d = 0;
          1:       d = 65535;
          2:       d = int'(tap_limit) - 1 + int'($urandom_range(2));
          3:       d = int'(hold_limit) - 1 + int'($urandom_range(2));
          4, 5, 6: d = (tap_limit > 1) ? int'($urandom_range(tap_limit - 1, 1)) : 1;
          7:       d = (hold_limit > tap_limit)
                       ? int'($urandom_range(hold_limit - 1, tap_limit))
                       : int'(tap_limit);
          8:       d = int'($urandom_range(65535));
          default: d = int'($urandom_range(65535, top));
        endcase
        if (d > 65535) d = 65535;
        words_to_send.push_back(press(2'($urandom_range(3)), MS_W'(d)));
        added++;
      end else begin
        n = ($urandom_range(9) == 0) ? int'($urandom_range(120, 40))
                                     : int'($urandom_range(12, 1));
        repeat (n)
          words_to_send.push_back(tick_word(2'($urandom_range(3)),
                                            MS_W'($urandom_range(65535))));
        added += n;
      end
    end
  endtask

  // One phase: drain, write both limits, set idling, random traffic, optional hold-off.
  task automatic run_phase(int tap, int hold, int s_idle, int r_stall, bit pressure);
    drain();
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= CFG_TAP_LIMIT;
    cfg_data  <= CFG_W'(tap);
    @(posedge clk);
    cfg_index <= CFG_HOLD_LIMIT;
    cfg_data  <= CFG_W'(hold);
    @(posedge clk);
    cfg_write          <= 1'b0;
    sender_idle_pct    <= s_idle;
    receiver_stall_pct <= r_stall;
    tap_limit  = MS_W'(tap);
    hold_limit = MS_W'(hold);
    queue_random(236);
    if (pressure) begin
      hold_off_start <= 1'b1;
      @(posedge clk);
      hold_off_start <= 1'b0;
    end
  endtask

  initial begin
    tap_limit  = TAP_LIMIT_RESET;
    hold_limit = HOLD_LIMIT_RESET;
    tick_phase = '0;
    for (int i = 0; i < NUM_CH; i++) ch_mode[i] = MODE_OFF;
    slow_arm   = '0;
    fast_arm   = '0;
    led_drive  = '0;
    first_tap  = '0;
    second_tap = '0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed words at the reset limits, no idling.
    words_to_send.push_back(tick_word(2'd3, 16'hFFFF)); // junk fields on a tick
    words_to_send.push_back(press(2'd0, 16'd0));        // zero duration does nothing
    words_to_send.push_back(press(2'd0, 16'd1));        // first tap: on
    words_to_send.push_back(press(2'd0, 16'd1499));     // second tap: ignored
    words_to_send.push_back(press(2'd0, 16'd1));        // third tap: off
    words_to_send.push_back(press(2'd0, 16'd1499));     // cycle restarts: on
    words_to_send.push_back(press(2'd1, 16'd1500));     // short hold at the tap limit
    words_to_send.push_back(press(2'd1, 16'd2999));
    words_to_send.push_back(press(2'd2, 16'd3000));     // long hold at the hold limit
    words_to_send.push_back(press(2'd3, 16'hFFFF));     // saturated duration
    words_to_send.push_back(press(2'd3, 16'd1));        // tap after a hold
    words_to_send.push_back(press(2'd3, 16'd1500));
    words_to_send.push_back(press(2'd3, 16'd1));        // ignored second tap, mode stays
    words_to_send.push_back(press(2'd3, 16'd1));        // third tap: off
    words_to_send.push_back(press(2'd1, 16'd1));
    words_to_send.push_back(tick_word(2'd0, 16'd0));

    // Random phases across limit extremes, crossed limits and idling mixes.
    run_phase(1, 65535, 61, 0, 1'b0);
    run_phase(65535, 1, 0, 61, 1'b0);
    run_phase(3000, 1000, 19, 19, 1'b0);
    run_phase($urandom_range(65535, 1), $urandom_range(65535, 1), 0, 0, 1'b1);
    run_phase(1500, 3000, 19, 19, 1'b0);

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && results_due.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #(40_000_000);
    $display("Test completed with failures");
    $finish;
  end

endmodule

### files.f
hw/rtl/pdlb_pkg.sv
hw/rtl/press_duration_led_blink_controller_unit.sv
sim/tb.sv
